### src/bmalloc_pkg.sv
// Shared types and constants for the bitmap allocator with free-index cache.
package bmalloc_pkg;

	localparam int MAP_WORDS_DEF   = 32;
	localparam int CACHE_SLOTS_DEF = 8;

	localparam int WORD_BITS  = 32;
	localparam int ENTRY_W    = 10;
	localparam int WORDS_W    = 6;
	localparam int SLOTS_W    = 4;
	localparam int CFG_DATA_W = 6;

	localparam logic [WORDS_W-1:0] WORDS_RESET = 6'd32;
	localparam logic [SLOTS_W-1:0] SLOTS_RESET = 4'd8;
	localparam logic [31:0]        ALL_USED    = 32'hFFFF_FFFF;

	// configuration register indexes
	localparam logic CFG_WORDS = 1'b0;
	localparam logic CFG_SLOTS = 1'b1;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_FIND  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_NO_FREE = 2'd1,
		STS_RANGE   = 2'd2
	} result_t;

	typedef enum logic [2:0] {
		RES_KEEP,
		RES_OK_ZERO,
		RES_NO_FREE,
		RES_RANGE,
		RES_FOUND
	} res_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TAKE,
		ST_SET_RD,
		ST_SET_WR,
		ST_REFILL_RD,
		ST_REFILL_LD,
		ST_REFILL_SCAN,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_FIND_RD,
		ST_FIND_CHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic     capture;
		logic     take;
		logic     flag_clr;
		logic     flag_set;
		logic     scan_init;
		logic     word_inc;
		logic     mem_rd;
		logic     wr_set;
		logic     wr_clr;
		logic     work_load;
		logic     fill;
		logic     clear_all;
		logic     out_load;
		res_sel_t res;
	} dp_cmd_t;

	typedef struct packed {
		logic hit;
		logic flag;
		logic word_in_map;
		logic scan_more;
		logic room;
		logic work_full;
		logic word_full;
		logic out_free;
	} dp_sts_t;

endpackage

### src/bmalloc_dpath.sv
// Datapath: bitmap memory, free-index cache, scan registers, config and result registers.
module bmalloc_dpath import bmalloc_pkg::*; #(
	parameter int MAP_WORDS   = MAP_WORDS_DEF,
	parameter int CACHE_SLOTS = CACHE_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [ENTRY_W-1:0]    in_index,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata
);

	localparam int MAP_DEPTH = (MAP_WORDS < WORD_BITS) ? MAP_WORDS : WORD_BITS;
	localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int SW        = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
	localparam int CNT_W     = $clog2(CACHE_SLOTS + 1);
	localparam int CW        = (CNT_W > SLOTS_W) ? CNT_W : SLOTS_W;

	function automatic logic [4:0] low_zero(input logic [31:0] w);
		logic [4:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) r = 5'(i);
		end
		return r;
	endfunction

	logic [WORDS_W-1:0]   words_q;
	logic [SLOTS_W-1:0]   slots_q;
	logic [WORDS_W-1:0]   nw;
	logic [CW-1:0]        ns;

	logic [31:0]          mem [MAP_DEPTH];
	logic [MAP_DEPTH-1:0] word_vld_q;
	logic [31:0]          rd_data_q;
	logic                 rd_vld_q;
	logic [31:0]          rd_word;
	logic [31:0]          bit_mask;

	logic [CACHE_SLOTS-1:0] slot_vld_q;
	logic [ENTRY_W-1:0]     slot_idx_q [CACHE_SLOTS];
	logic                   hit;
	logic [SW-1:0]          hit_slot;
	logic                   flag_q;

	logic [WORDS_W-1:0]   word_q;
	logic [4:0]           bit_q;
	logic [CW-1:0]        filled_q;
	logic [31:0]          work_q;
	logic [4:0]           work_bit;

	logic [ENTRY_W-1:0]   res_entry_q;
	result_t              res_status_q;
	logic                 out_valid_q;
	logic [ENTRY_W-1:0]   out_entry_q;
	result_t              out_status_q;

	logic [AW-1:0]        addr;

	assign addr = word_q[AW-1:0];

	always_comb begin
		nw = (words_q > WORDS_W'(MAP_DEPTH)) ? WORDS_W'(MAP_DEPTH) : words_q;
		ns = (CW'(slots_q) > CW'(CACHE_SLOTS)) ? CW'(CACHE_SLOTS) : CW'(slots_q);
	end

	// lowest valid slot among those in use
	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
			if (slot_vld_q[i] && (CW'(i) < ns)) begin
				hit      = 1'b1;
				hit_slot = SW'(i);
			end
		end
	end

	// a word never written since clear reads as all free
	assign rd_word  = rd_vld_q ? rd_data_q : '0;
	assign bit_mask = 32'd1 << bit_q;
	assign work_bit = low_zero(work_q);

	always_comb begin
		sts.hit         = hit;
		sts.flag        = flag_q;
		sts.word_in_map = word_q < WORDS_W'(MAP_DEPTH);
		sts.scan_more   = word_q < nw;
		sts.room        = filled_q < ns;
		sts.work_full   = work_q == ALL_USED;
		sts.word_full   = rd_word == ALL_USED;
		sts.out_free    = !out_valid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q     <= WORDS_RESET;
			slots_q     <= SLOTS_RESET;
			word_vld_q  <= '0;
			rd_vld_q    <= 1'b0;
			slot_vld_q  <= '0;
			flag_q      <= 1'b0;
			word_q      <= '0;
			bit_q       <= '0;
			filled_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_WORDS) words_q <= cfg_data;
				else                        slots_q <= cfg_data[SLOTS_W-1:0];
			end
			if (cmd.capture) begin
				word_q <= {1'b0, in_index[9:5]};
				bit_q  <= in_index[4:0];
			end
			if (cmd.take) begin
				word_q               <= {1'b0, slot_idx_q[hit_slot][9:5]};
				bit_q                <= slot_idx_q[hit_slot][4:0];
				slot_vld_q[hit_slot] <= 1'b0;
			end
			if (cmd.flag_clr) flag_q <= 1'b0;
			if (cmd.flag_set) flag_q <= 1'b1;
			if (cmd.scan_init) begin
				word_q   <= '0;
				filled_q <= '0;
			end
			if (cmd.word_inc) word_q <= word_q + 1'b1;
			if (cmd.mem_rd) rd_vld_q <= word_vld_q[addr];
			if (cmd.wr_set || cmd.wr_clr) word_vld_q[addr] <= 1'b1;
			if (cmd.fill) begin
				slot_vld_q[filled_q[SW-1:0]] <= 1'b1;
				filled_q                     <= filled_q + 1'b1;
			end
			if (cmd.clear_all) begin
				slot_vld_q <= '0;
				word_vld_q <= '0;
				flag_q     <= 1'b0;
			end
			if (cmd.out_load)  out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) rd_data_q <= mem[addr];
		if (cmd.wr_set) mem[addr] <= rd_word | bit_mask;
		if (cmd.wr_clr) mem[addr] <= rd_word & ~bit_mask;
	end

	always_ff @(posedge clk) begin
		if (cmd.work_load) work_q <= rd_word;
		if (cmd.fill) begin
			slot_idx_q[filled_q[SW-1:0]] <= {word_q[4:0], work_bit};
			work_q                       <= work_q | (32'd1 << work_bit);
		end
		if (cmd.take) begin
			res_entry_q  <= slot_idx_q[hit_slot];
			res_status_q <= STS_OK;
		end
		case (cmd.res)
			RES_OK_ZERO: begin
				res_entry_q  <= '0;
				res_status_q <= STS_OK;
			end
			RES_NO_FREE: begin
				res_entry_q  <= '0;
				res_status_q <= STS_NO_FREE;
			end
			RES_RANGE: begin
				res_entry_q  <= '0;
				res_status_q <= STS_RANGE;
			end
			RES_FOUND: begin
				res_entry_q  <= {word_q[4:0], low_zero(rd_word)};
				res_status_q <= STS_OK;
			end
			default: ;
		endcase
		if (cmd.out_load) begin
			out_entry_q  <= res_entry_q;
			out_status_q <= res_status_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_status_q, out_entry_q};

	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_set || cmd.wr_clr) |-> $past(cmd.mem_rd) && sts.word_in_map)
		else $error("bitmap write without a preceding read of the same word");

	a_fill_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill |-> sts.room)
		else $error("cache fill beyond the slots in use");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_all |=> (slot_vld_q == '0) && (word_vld_q == '0) && !flag_q)
		else $error("clear left cache or bitmap state behind");

endmodule

### src/bmalloc_ctrl.sv
// Controller: sequences allocate, refill, free, find and clear over the datapath.
module bmalloc_ctrl import bmalloc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  op_t     op,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q, state_d;
	logic   second_q, second_d;
	logic   accept;

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		second_d = second_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					second_d = 1'b0;
					case (op)
						OP_ALLOC: state_d = ST_TAKE;
						OP_FREE: begin
							cmd.capture = 1'b1;
							state_d     = ST_FREE_RD;
						end
						OP_FIND: begin
							cmd.scan_init = 1'b1;
							state_d       = ST_FIND_RD;
						end
						default: begin
							cmd.clear_all = 1'b1;
							cmd.res       = RES_OK_ZERO;
							state_d       = ST_DONE;
						end
					endcase
				end
			end
			ST_TAKE: begin
				if (sts.hit) begin
					cmd.take     = 1'b1;
					cmd.flag_clr = 1'b1;
					state_d      = ST_SET_RD;
				end else if (second_q || sts.flag) begin
					cmd.flag_clr = 1'b1;
					cmd.res      = RES_NO_FREE;
					state_d      = ST_DONE;
				end else begin
					cmd.scan_init = 1'b1;
					second_d      = 1'b1;
					state_d       = ST_REFILL_RD;
				end
			end
			ST_SET_RD: begin
				// a stale slot may point past the bitmap: hand it out untouched
				if (sts.word_in_map) begin
					cmd.mem_rd = 1'b1;
					state_d    = ST_SET_WR;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SET_WR: begin
				cmd.wr_set = 1'b1;
				state_d    = ST_DONE;
			end
			ST_REFILL_RD: begin
				if (sts.scan_more && sts.room) begin
					cmd.mem_rd = 1'b1;
					state_d    = ST_REFILL_LD;
				end else begin
					cmd.flag_set = 1'b1;
					state_d      = ST_TAKE;
				end
			end
			ST_REFILL_LD: begin
				cmd.work_load = 1'b1;
				state_d       = ST_REFILL_SCAN;
			end
			ST_REFILL_SCAN: begin
				if (!sts.room) begin
					cmd.flag_set = 1'b1;
					state_d      = ST_TAKE;
				end else if (sts.work_full) begin
					cmd.word_inc = 1'b1;
					state_d      = ST_REFILL_RD;
				end else begin
					cmd.fill = 1'b1;
				end
			end
			ST_FREE_RD: begin
				if (sts.scan_more) begin
					cmd.mem_rd = 1'b1;
					state_d    = ST_FREE_WR;
				end else begin
					cmd.res = RES_RANGE;
					state_d = ST_DONE;
				end
			end
			ST_FREE_WR: begin
				cmd.wr_clr = 1'b1;
				cmd.res    = RES_OK_ZERO;
				state_d    = ST_DONE;
			end
			ST_FIND_RD: begin
				if (sts.scan_more) begin
					cmd.mem_rd = 1'b1;
					state_d    = ST_FIND_CHK;
				end else begin
					cmd.res = RES_NO_FREE;
					state_d = ST_DONE;
				end
			end
			ST_FIND_CHK: begin
				if (!sts.word_full) begin
					cmd.res = RES_FOUND;
					state_d = ST_DONE;
				end else begin
					cmd.word_inc = 1'b1;
					state_d      = ST_FIND_RD;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("item accepted but controller stayed idle");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !sts.out_free) |=> state_q == ST_DONE)
		else $error("result dropped while output register busy");

	a_one_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAKE && second_q) |-> !cmd.scan_init)
		else $error("second refill started for one allocate");

endmodule

### src/bitmap_allocator_with_free_cache.sv
// Top level: bitmap allocator with free-index cache.
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    s_tdata: opcode[1:0], index[11:2]
//  m_*      out  m_tvalid / m_tready    m_tdata: entry[9:0], status[11:10]
//  cfg_*    in   cfg_valid / cfg_ready  cfg_index (0 words, 1 slots), cfg_data
//
// One item is in flight at a time; the result sits in an output register so the
// next item is taken while it waits. Find reads the bitmap word by word until one
// has a free bit. A refill reads each word it visits through the single bitmap
// memory port and fills one slot per cycle until it runs out of words or slots.
// Reset empties the bitmap (per-word valid bits) and the cache at once.
// A stalled output holds the controller in its final state; nothing is dropped.
module bitmap_allocator_with_free_cache import bmalloc_pkg::*; #(
	parameter int MAP_WORDS   = MAP_WORDS_DEF,
	parameter int CACHE_SLOTS = CACHE_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // opcode[1:0], index[11:2], zero pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // entry[9:0], status[11:10], zero pad
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	bmalloc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (op_t'(s_tdata[1:0])),
		.sts      (sts),
		.cmd      (cmd)
	);

	bmalloc_dpath #(
		.MAP_WORDS   (MAP_WORDS),
		.CACHE_SLOTS (CACHE_SLOTS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_index  (s_tdata[11:2]),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

### tb/sv/tb_bitmap_allocator_with_free_cache.sv
// Self-checking testbench for the bitmap allocator with free-index cache.
module tb_bitmap_allocator_with_free_cache;
	import bmalloc_pkg::*;

	localparam int RANDOM_ITEMS = 1350;
	localparam int IDLE_LIMIT   = 4000;
	localparam int TAIL_CYCLES  = 150;
	localparam int MAX_REPORTS  = 100;

	typedef struct packed {
		logic [ENTRY_W-1:0] entry;
		result_t            status;
	} reply_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_CHECK,
		ROW_TYPED
	} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic               cfg_sel;
		op_t                op;
		logic [9:0]         arg;
		logic [ENTRY_W-1:0] e;
		result_t            s;
	} row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [15:0]           s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [15:0]           m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_index = CFG_WORDS;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// predictor state
	logic [31:0]        bitmap_m [32];
	logic [10:0]        slot_m [8];
	bit                 scanned_m;
	logic [WORDS_W-1:0] words_reg;
	logic [SLOTS_W-1:0] slots_reg;

	reply_t reply_q [$];
	reply_t want;
	int     fails      = 0;
	int     idle_count = 0;
	int     stall_left = 0;
	bit     calm       = 1'b0;
	row_t   plan [29];

	bitmap_allocator_with_free_cache DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int live_words();
		return (words_reg > 6'd32) ? 32 : int'(words_reg);
	endfunction

	function automatic int live_slots();
		return (slots_reg > 4'd8) ? 8 : int'(slots_reg);
	endfunction

	function automatic bit pop_cached(output logic [ENTRY_W-1:0] e);
		e = '0;
		for (int i = 0; i < live_slots(); i++) begin
			if (slot_m[i][10]) begin
				e = slot_m[i][9:0];
				slot_m[i] = '0;
				bitmap_m[e[9:5]][e[4:0]] = 1'b1;
				scanned_m = 1'b0;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void refill_slots();
		int nw;
		int ns;
		int filled;
		nw = live_words();
		ns = live_slots();
		filled = 0;
		for (int w = 0; w < nw && filled < ns; w++) begin
			if (bitmap_m[w] != ALL_USED) begin
				for (int b = 0; b < WORD_BITS && filled < ns; b++) begin
					if (!bitmap_m[w][b]) begin
						slot_m[filled] = {1'b1, 10'(w * WORD_BITS + b)};
						filled++;
					end
				end
			end
		end
		scanned_m = 1'b1;
	endfunction

	function automatic bit lowest_free(output logic [ENTRY_W-1:0] e);
		e = '0;
		for (int w = 0; w < live_words(); w++) begin
			if (bitmap_m[w] != ALL_USED) begin
				for (int b = 0; b < WORD_BITS; b++) begin
					if (!bitmap_m[w][b]) begin
						e = 10'(w * WORD_BITS + b);
						return 1'b1;
					end
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic void wipe_state();
		foreach (bitmap_m[w]) bitmap_m[w] = '0;
		foreach (slot_m[i]) slot_m[i] = '0;
		scanned_m = 1'b0;
	endfunction

	// Advance the predicted allocator by one item and return its reply.
	function automatic reply_t compute_reply(op_t op, logic [9:0] idx);
		reply_t r;
		logic [ENTRY_W-1:0] e;
		result_t s;
		e = '0;
		s = STS_OK;
		case (op)
			OP_ALLOC: begin
				if (!pop_cached(e)) begin
					if (scanned_m) begin
						scanned_m = 1'b0;
						s = STS_NO_FREE;
					end else begin
						refill_slots();
						if (!pop_cached(e)) begin
							scanned_m = 1'b0;
							s = STS_NO_FREE;
						end
					end
				end
			end
			OP_FREE: begin
				if (int'(idx) < live_words() * WORD_BITS)
					bitmap_m[idx[9:5]][idx[4:0]] = 1'b0;
				else
					s = STS_RANGE;
			end
			OP_FIND: begin
				if (!lowest_free(e))
					s = STS_NO_FREE;
			end
			default: wipe_state();
		endcase
		if (s != STS_OK)
			e = '0;
		r.entry = e;
		r.status = s;
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Present one item, hold it until taken, then queue its reply.
	task automatic send_item(op_t op, logic [9:0] idx, bit typed, logic [ENTRY_W-1:0] e,
			result_t s);
		reply_t r;
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, idx, op};
		do @(posedge clk); while (!s_tready);
		r = compute_reply(op, idx);
		if (typed) begin
			r.entry = e;
			r.status = s;
		end
		reply_q.push_back(r);
		gap = calm ? 0 : idle_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the sender until every reply is back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic sel, logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (sel == CFG_WORDS)
			words_reg = val;
		else
			slots_reg = val[SLOTS_W-1:0];
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (reply_q.size() == 0) begin
					fails++;
					if (fails <= MAX_REPORTS)
						$display("%0t: reply with none expected: entry %0d status %0d",
							$time, m_tdata[9:0], m_tdata[11:10]);
				end else begin
					want = reply_q.pop_front();
					if (m_tdata[9:0] !== want.entry) begin
						fails++;
						if (fails <= MAX_REPORTS)
							$display("%0t: entry expected %0d got %0d",
								$time, want.entry, m_tdata[9:0]);
					end
					if (m_tdata[11:10] !== want.status) begin
						fails++;
						if (fails <= MAX_REPORTS)
							$display("%0t: status expected %0d got %0d",
								$time, want.status, m_tdata[11:10]);
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_count = 0;
			else
				idle_count++;
			if (idle_count >= IDLE_LIMIT) begin
				$display("[bitmap_allocator_with_free_cache] ERROR");
				$finish;
			end
			if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					stall_left = idle_len();
			end
		end
	end

	initial begin
		op_t op;
		logic [9:0] idx;
		logic [CFG_DATA_W-1:0] val;
		int r;
		int sent;
		int phase_len;

		wipe_state();
		words_reg = WORDS_RESET;
		slots_reg = SLOTS_RESET;

		plan = '{
			'{ROW_TYPED, CFG_WORDS, OP_FIND,  10'd0,    10'd0, STS_OK},
			'{ROW_TYPED, CFG_WORDS, OP_ALLOC, 10'd0,    10'd0, STS_OK},
			'{ROW_TYPED, CFG_WORDS, OP_ALLOC, 10'd0,    10'd1, STS_OK},
			'{ROW_TYPED, CFG_WORDS, OP_FIND,  10'd0,    10'd2, STS_OK},
			'{ROW_TYPED, CFG_WORDS, OP_FREE,  10'd1023, 10'd0, STS_OK},
			'{ROW_TYPED, CFG_WORDS, OP_FREE,  10'd0,    10'd0, STS_OK},
			'{ROW_TYPED, CFG_WORDS, OP_FIND,  10'd0,    10'd0, STS_OK},
			'{ROW_CHECK, CFG_WORDS, OP_ALLOC, 10'd1023, 10'd0, STS_OK},
			'{ROW_TYPED, CFG_WORDS, OP_CLEAR, 10'd1023, 10'd0, STS_OK},
			// no words managed
			'{ROW_CFG,   CFG_WORDS, OP_ALLOC, 10'd0,    10'd0, STS_OK},
			'{ROW_TYPED, CFG_WORDS, OP_ALLOC, 10'd0,    10'd0, STS_NO_FREE},
			'{ROW_TYPED, CFG_WORDS, OP_FIND,  10'd0,    10'd0, STS_NO_FREE},
			'{ROW_TYPED, CFG_WORDS, OP_FREE,  10'd0,    10'd0, STS_RANGE},
			// both registers above their range
			'{ROW_CFG,   CFG_WORDS, OP_ALLOC, 10'd63,   10'd0, STS_OK},
			'{ROW_CFG,   CFG_SLOTS, OP_ALLOC, 10'd15,   10'd0, STS_OK},
			'{ROW_TYPED, CFG_WORDS, OP_ALLOC, 10'd0,    10'd0, STS_OK},
			'{ROW_TYPED, CFG_WORDS, OP_FREE,  10'd1023, 10'd0, STS_OK},
			// shrink to one word: stale slots stay valid
			'{ROW_CFG,   CFG_WORDS, OP_ALLOC, 10'd1,    10'd0, STS_OK},
			'{ROW_TYPED, CFG_WORDS, OP_FREE,  10'd32,   10'd0, STS_RANGE},
			'{ROW_TYPED, CFG_WORDS, OP_FREE,  10'd31,   10'd0, STS_OK},
			'{ROW_CHECK, CFG_WORDS, OP_ALLOC, 10'd0,    10'd0, STS_OK},
			// no slots usable, then one, then all again
			'{ROW_CFG,   CFG_SLOTS, OP_ALLOC, 10'd0,    10'd0, STS_OK},
			'{ROW_TYPED, CFG_WORDS, OP_ALLOC, 10'd0,    10'd0, STS_NO_FREE},
			'{ROW_CFG,   CFG_SLOTS, OP_ALLOC, 10'd1,    10'd0, STS_OK},
			'{ROW_CHECK, CFG_WORDS, OP_ALLOC, 10'd0,    10'd0, STS_OK},
			'{ROW_CFG,   CFG_SLOTS, OP_ALLOC, 10'd8,    10'd0, STS_OK},
			'{ROW_CHECK, CFG_WORDS, OP_ALLOC, 10'd0,    10'd0, STS_OK},
			'{ROW_TYPED, CFG_WORDS, OP_CLEAR, 10'd0,    10'd0, STS_OK},
			'{ROW_CFG,   CFG_WORDS, OP_ALLOC, 10'd32,   10'd0, STS_OK}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_CFG)
				write_reg(plan[k].cfg_sel, plan[k].arg[CFG_DATA_W-1:0]);
			else
				send_item(plan[k].op, plan[k].arg, plan[k].kind == ROW_TYPED,
					plan[k].e, plan[k].s);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0:       val = 6'd0;
				1, 8:    val = 6'd1;
				2, 3, 4: val = 6'($urandom_range(2, 4));
				5:       val = 6'($urandom_range(5, 8));
				6:       val = 6'd32;
				7:       val = 6'($urandom_range(33, 63));
				default: val = 6'($urandom_range(1, 2));
			endcase
			write_reg(CFG_WORDS, val);
			case ($urandom_range(0, 9))
				0:       val = 6'd0;
				1:       val = 6'd1;
				2, 3, 4: val = 6'($urandom_range(2, 7));
				5:       val = 6'd8;
				6:       val = 6'($urandom_range(9, 15));
				7:       val = 6'($urandom_range(0, 63));
				default: val = 6'($urandom_range(1, 3));
			endcase
			write_reg(CFG_SLOTS, val);

			phase_len = $urandom_range(30, 120);
			for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 50)
					op = OP_ALLOC;
				else if (r < 78)
					op = OP_FREE;
				else if (r < 94)
					op = OP_FIND;
				else
					op = OP_CLEAR;
				if (op == OP_FREE && live_words() > 0 && $urandom_range(0, 99) < 75)
					idx = 10'($urandom_range(0, live_words() * WORD_BITS - 1));
				else
					idx = 10'($urandom_range(0, 1023));
				send_item(op, idx, 1'b0, '0, STS_OK);
				sent++;
				if ($urandom_range(0, 99) < 3)
					drain();
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0 && reply_q.size() == 0)
			$display("[bitmap_allocator_with_free_cache] OK");
		else
			$display("[bitmap_allocator_with_free_cache] ERROR");
		$finish;
	end

endmodule

### files.f
src/bmalloc_pkg.sv
src/bmalloc_dpath.sv
src/bmalloc_ctrl.sv
src/bitmap_allocator_with_free_cache.sv
tb/sv/tb_bitmap_allocator_with_free_cache.sv
